// File: sv/sactr_pkg.sv
// shared constants, codes and helper functions of the cache tag and replacement engine
`timescale 1ns / 1ps

package sactr_pkg;

  // default geometry
  localparam int SETS_DEF        = 64;
  localparam int WAYS_DEF        = 4;
  localparam int BLOCK_BYTES_DEF = 16;
  localparam int ADDR_BITS_DEF   = 32;

  // fixed sizes
  localparam int ACCESS_BYTES = 8;
  localparam int STAMP_W      = 32;
  localparam int COUNT_W      = 32;
  localparam int ADDRESS_W    = 32;
  localparam int WAY_FIELD_W  = 2;
  localparam int SET_FIELD_W  = 6;
  localparam int TAG_FIELD_W  = 22;
  localparam int LFSR_W       = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 2'd0,
    CFG_POLICY = 2'd1,
    CFG_SEED   = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    POL_LRU    = 2'd0,
    POL_FIFO   = 2'd1,
    POL_RANDOM = 2'd2
  } policy_t;

  typedef enum logic {
    ACT_LOAD       = 1'b0,
    ACT_INVALIDATE = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_MOD,
    ST_CLEAR
  } state_t;

  // taps 16, 14, 13, 11 in a right-shifting register
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] l);
    logic fb;
    fb = l[0] ^ l[2] ^ l[3] ^ l[5];
    return {fb, l[LFSR_W-1:1]};
  endfunction

  // zero seed would lock the lfsr
  function automatic logic [LFSR_W-1:0] seed_load(input logic [LFSR_W-1:0] s);
    return (s == '0) ? LFSR_W'(1) : s;
  endfunction

endpackage

// File: sv/sactr_if.sv
// request, response and configuration channel interfaces
`timescale 1ns / 1ps

interface sactr_req_if
  import sactr_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [ADDRESS_W-1:0] address;

  modport source (output valid, action, address, input ready);
  modport sink   (input valid, action, address, output ready);
endinterface

interface sactr_rsp_if
  import sactr_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic                   allocated;
  logic [WAY_FIELD_W-1:0] way_used;
  logic [SET_FIELD_W-1:0] set_used;
  logic                   evicted_valid;
  logic [TAG_FIELD_W-1:0] evicted_tag;
  logic [COUNT_W-1:0]     access_total;
  logic [COUNT_W-1:0]     hit_total;
  logic [COUNT_W-1:0]     miss_total;

  modport source (output valid, hit, allocated, way_used, set_used, evicted_valid,
                  evicted_tag, access_total, hit_total, miss_total, input ready);
  modport sink   (input valid, hit, allocated, way_used, set_used, evicted_valid,
                  evicted_tag, access_total, hit_total, miss_total, output ready);
endinterface

interface sactr_cfg_if
  import sactr_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// File: sv/set_assoc_cache_tag_replacement_core.sv
// top level of the set-associative cache tag and replacement engine
`timescale 1ns / 1ps

// usage
//   req: one request per lookup; action load looks up address, action invalidate
//   clears every valid bit. rsp: one response per request with hit / fill info,
//   the evicted tag and running access, hit and miss totals. cfg: register writes
//   (enable, replacement policy, lfsr seed), always ready; the user must write only
//   while idle, which the block itself does not enforce.
// request sequence
//   an accepted request reads its set's tag/stamp row and valid bits; the lookup
//   state then registers the response for hits, plain misses and fills of an
//   invalid way. a full-set fill first steps through the scan state under lru /
//   fifo (one stamp compare per cycle) or, with random replacement and WAYS not
//   a power of two, the mod state for the reciprocal remainder. an invalidate
//   answers, then clears one valid ram set per cycle, taking no request until done.
// reset
//   synchronous rst clears counters, registers (disabled, lru, seed 1) and the
//   response register, then a pass over every set zeroes the valid ram; req.ready
//   stays low until it ends. tags and stamps are read only for valid ways.
// stall
//   a new request is taken while a response still waits; the commit of the
//   next one holds until the response register is taken.

module set_assoc_cache_tag_replacement_core
  import sactr_pkg::*;
#(
  parameter int SETS        = SETS_DEF,
  parameter int WAYS        = WAYS_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  sactr_req_if.sink   req,
  sactr_rsp_if.source rsp,
  sactr_cfg_if.sink   cfg
);

  // address split
  localparam int OFF_W     = $clog2(BLOCK_BYTES);
  localparam int SET_BITS  = $clog2(SETS);
  localparam int SET_W     = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int WAY_BITS  = $clog2(WAYS);
  localparam int WAY_W     = (WAY_BITS > 0) ? WAY_BITS : 1;
  localparam int TAG_BITS  = (ADDR_BITS > OFF_W + SET_BITS) ? ADDR_BITS - OFF_W - SET_BITS : 0;
  localparam int TAG_W     = (TAG_BITS > 0) ? TAG_BITS : 1;
  localparam int FIT_MAX   = BLOCK_BYTES - ACCESS_BYTES;
  // one ram row per set: per way {tag, last use stamp, fill stamp}
  localparam int ENTRY_W   = TAG_W + 2 * STAMP_W;
  localparam int ROW_W     = WAYS * ENTRY_W;
  localparam bit WAYS_POW2 = (WAYS == (1 << WAY_BITS));
  // lfsr mod WAYS by reciprocal multiply, exact for every 16-bit value
  localparam int     RECIP_SH = LFSR_W + WAY_BITS;
  localparam int     RECIP_W  = LFSR_W + 2;
  localparam int     PROD_W   = LFSR_W + RECIP_W;
  localparam longint RECIP    = ((longint'(1) << RECIP_SH) + longint'(WAYS) - 1)
                                / longint'(WAYS);

  function automatic logic [SET_W-1:0] set_of(input logic [ADDRESS_W-1:0] a);
    logic [ADDR_BITS-1:0] ax;
    ax = ADDR_BITS'(a);
    return (SET_BITS > 0) ? SET_W'(ax >> OFF_W) : '0;
  endfunction

  function automatic logic [TAG_W-1:0] tag_of(input logic [ADDRESS_W-1:0] a);
    logic [ADDR_BITS-1:0] ax;
    ax = ADDR_BITS'(a);
    return (TAG_BITS > 0) ? TAG_W'(ax >> (OFF_W + SET_BITS)) : '0;
  endfunction

  state_t state, state_next;

  // configuration registers
  logic                 cache_en;
  logic [1:0]           policy;
  logic [LFSR_W-1:0]    lfsr;

  // request held during lookup
  action_t              act_q;
  logic [SET_W-1:0]     set_q;
  logic [TAG_W-1:0]     tag_q;
  logic [OFF_W-1:0]     off_q;

  // valid ram, one row of WAYS bits per set, cleared by a pass over all sets
  logic                 clearing, valid_we;
  logic [SET_W-1:0]     clr_idx, valid_waddr;
  logic [WAYS-1:0]      valid_rd, valid_wdata;

  // statistics; the miss count doubles as the fill stamp source
  logic [COUNT_W-1:0]   access_cnt, hit_cnt, miss_cnt;
  logic [COUNT_W-1:0]   access_next, miss_next;

  // set ram
  logic                 ram_re, ram_we;
  logic [ROW_W-1:0]     rd_row, row_new;

  // lookup decode
  logic [TAG_W-1:0]     way_tag   [WAYS];
  logic [STAMP_W-1:0]   use_stamp [WAYS];
  logic [STAMP_W-1:0]   fill_stmp [WAYS];
  logic [WAYS-1:0]      set_valid, hit_vec;
  logic                 hit_any, free_any, fits, can_alloc;
  logic [WAY_W-1:0]     hit_way, free_way;

  // lru / fifo scan
  logic [WAY_W-1:0]     scan_idx, scan_best, new_best;
  logic [STAMP_W-1:0]   scan_best_stamp, cand_stamp, first_stamp;
  logic                 better, scan_start, scan_step;

  // lfsr remainder
  logic [LFSR_W-1:0]    mod_dvd, mod_quo, mod_back;
  logic [PROD_W-1:0]    mod_prod;
  logic [WAY_W-1:0]     rem_new;
  logic                 mod_start, lfsr_adv;

  // commit of one request
  logic                 slot_free;
  logic                 c_go, c_hit, c_alloc, c_evict, c_inval;
  logic [WAY_W-1:0]     c_way;

  // response register
  logic                   out_valid, out_hit, out_alloc, out_ev_valid;
  logic [WAY_FIELD_W-1:0] out_way;
  logic [SET_FIELD_W-1:0] out_set;
  logic [TAG_FIELD_W-1:0] out_ev_tag;
  logic [COUNT_W-1:0]     out_access, out_hits, out_misses;

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign slot_free = !out_valid || rsp.ready;

  assign access_next = access_cnt + COUNT_W'(1);
  assign miss_next   = miss_cnt + COUNT_W'(1);

  // ---------------------------------------------------------------- set ram
  assign ram_re = req.valid && req.ready;
  assign ram_we = c_go && (c_hit || c_alloc);

  sactr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_set_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (set_q),
    .wdata (row_new),
    .re    (ram_re),
    .raddr (set_of(req.address)),
    .rdata (rd_row)
  );

  // ---------------------------------------------------------------- valid ram
  assign clearing    = (state == ST_CLEAR);
  assign valid_we    = clearing || (c_go && c_alloc);
  assign valid_waddr = clearing ? clr_idx : set_q;
  assign valid_wdata = clearing ? '0 : (valid_rd | (WAYS'(1) << c_way));

  sactr_ram #(
    .WIDTH (WAYS),
    .DEPTH (SETS)
  ) u_valid_ram (
    .clk   (clk),
    .we    (valid_we),
    .waddr (valid_waddr),
    .wdata (valid_wdata),
    .re    (ram_re),
    .raddr (set_of(req.address)),
    .rdata (valid_rd)
  );

  // ---------------------------------------------------------------- lookup decode
  assign set_valid = valid_rd;
  assign fits      = (off_q <= OFF_W'(FIT_MAX));
  assign can_alloc = cache_en && (off_q == '0);

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      way_tag[w]   = rd_row[w * ENTRY_W + 2 * STAMP_W +: TAG_W];
      use_stamp[w] = rd_row[w * ENTRY_W + STAMP_W +: STAMP_W];
      fill_stmp[w] = rd_row[w * ENTRY_W +: STAMP_W];
      hit_vec[w]   = cache_en && fits && set_valid[w] && (way_tag[w] == tag_q);
    end
    hit_any  = |hit_vec;
    free_any = !(&set_valid);
    hit_way  = '0;
    free_way = '0;
    // lowest way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!set_valid[w]) begin
        free_way = WAY_W'(w);
      end
    end
  end

  // stamp picked by policy; ties keep the lower way
  assign first_stamp = (policy == POL_FIFO) ? fill_stmp[0] : use_stamp[0];
  assign cand_stamp  = (policy == POL_FIFO) ? fill_stmp[scan_idx] : use_stamp[scan_idx];
  assign better      = (cand_stamp < scan_best_stamp);
  assign new_best    = better ? scan_idx : scan_best;

  // quotient taken at the lookup edge, remainder formed in the next cycle
  assign mod_prod = PROD_W'(lfsr_step(lfsr)) * PROD_W'(RECIP);
  assign mod_back = mod_quo * LFSR_W'(WAYS);
  assign rem_new  = WAY_W'(mod_dvd - mod_back);

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    c_go       = 1'b0;
    c_hit      = 1'b0;
    c_alloc    = 1'b0;
    c_evict    = 1'b0;
    c_inval    = 1'b0;
    c_way      = '0;
    scan_start = 1'b0;
    scan_step  = 1'b0;
    mod_start  = 1'b0;
    lfsr_adv   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (act_q == ACT_INVALIDATE) begin
          c_go    = slot_free;
          c_inval = 1'b1;
        end else if (hit_any) begin
          c_go  = slot_free;
          c_hit = 1'b1;
          c_way = hit_way;
        end else if (!can_alloc) begin
          c_go = slot_free;
        end else if (free_any) begin
          c_go    = slot_free;
          c_alloc = 1'b1;
          c_way   = free_way;
        end else begin
          case (policy)
            POL_LRU, POL_FIFO: begin
              if (WAYS > 1) begin
                scan_start = 1'b1;
                state_next = ST_SCAN;
              end else begin
                c_go    = slot_free;
                c_alloc = 1'b1;
                c_evict = 1'b1;
              end
            end
            POL_RANDOM: begin
              if (WAYS_POW2) begin
                c_go     = slot_free;
                c_alloc  = 1'b1;
                c_evict  = 1'b1;
                c_way    = WAY_W'(lfsr_step(lfsr)) & WAY_W'(WAYS - 1);
                lfsr_adv = slot_free;
              end else begin
                mod_start  = 1'b1;
                lfsr_adv   = 1'b1;
                state_next = ST_MOD;
              end
            end
            default: begin
              // unused policy code evicts way 0
              c_go    = slot_free;
              c_alloc = 1'b1;
              c_evict = 1'b1;
            end
          endcase
        end
        if (c_go) begin
          state_next = c_inval ? ST_CLEAR : ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_idx == WAY_W'(WAYS - 1)) begin
          c_go    = slot_free;
          c_alloc = 1'b1;
          c_evict = 1'b1;
          c_way   = new_best;
          if (slot_free) begin
            state_next = ST_IDLE;
          end
        end else begin
          scan_step = 1'b1;
        end
      end
      ST_MOD: begin
        c_go    = slot_free;
        c_alloc = 1'b1;
        c_evict = 1'b1;
        c_way   = rem_new;
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (clr_idx == SET_W'(SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- request capture
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      act_q <= action_t'(req.action);
      set_q <= set_of(req.address);
      tag_q <= tag_of(req.address);
      off_q <= OFF_W'(req.address);
    end
  end

  // ---------------------------------------------------------------- clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (clearing) begin
      clr_idx <= (clr_idx == SET_W'(SETS - 1)) ? '0 : clr_idx + SET_W'(1);
    end
  end

  // ---------------------------------------------------------------- scan and remainder
  always_ff @(posedge clk) begin
    if (scan_start) begin
      scan_best       <= '0;
      scan_best_stamp <= first_stamp;
      scan_idx        <= WAY_W'(1);
    end else if (scan_step) begin
      scan_best       <= new_best;
      scan_best_stamp <= better ? cand_stamp : scan_best_stamp;
      scan_idx        <= scan_idx + WAY_W'(1);
    end
    if (mod_start) begin
      mod_dvd <= lfsr_step(lfsr);
      mod_quo <= LFSR_W'(mod_prod >> RECIP_SH);
    end
  end

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_en <= 1'b0;
      policy   <= POL_LRU;
      lfsr     <= LFSR_W'(1);
    end else begin
      if (cfg.valid) begin
        case (cfg.reg_index)
          CFG_ENABLE: cache_en <= cfg.wdata[0];
          CFG_POLICY: policy   <= cfg.wdata[1:0];
          CFG_SEED:   lfsr     <= seed_load(cfg.wdata);
          default:    ;
        endcase
      end
      if (lfsr_adv) begin
        lfsr <= lfsr_step(lfsr);
      end
    end
  end

  // ---------------------------------------------------------------- write-back row
  always_comb begin
    logic [ENTRY_W-1:0] e;
    row_new = rd_row;
    for (int w = 0; w < WAYS; w++) begin
      e = rd_row[w * ENTRY_W +: ENTRY_W];
      if (WAY_W'(w) == c_way) begin
        if (c_alloc) begin
          e = {tag_q, access_next, miss_next};
        end else if (c_hit) begin
          e[STAMP_W +: STAMP_W] = access_next;
        end
      end
      row_new[w * ENTRY_W +: ENTRY_W] = e;
    end
  end

  // ---------------------------------------------------------------- counters
  always_ff @(posedge clk) begin
    if (rst) begin
      access_cnt <= '0;
      hit_cnt    <= '0;
      miss_cnt   <= '0;
    end else if (c_go && !c_inval) begin
      access_cnt <= access_next;
      if (c_hit) begin
        hit_cnt <= hit_cnt + COUNT_W'(1);
      end else begin
        miss_cnt <= miss_next;
      end
    end
  end

  // ---------------------------------------------------------------- response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_go) begin
      out_hit      <= c_hit;
      out_alloc    <= c_alloc;
      out_way      <= (c_hit || c_alloc) ? WAY_FIELD_W'(c_way) : '0;
      out_set      <= c_inval ? '0 : SET_FIELD_W'(set_q);
      out_ev_valid <= c_evict;
      out_ev_tag   <= c_evict ? TAG_FIELD_W'(way_tag[c_way]) : '0;
      out_access   <= c_inval ? access_cnt : access_next;
      out_hits     <= c_hit ? hit_cnt + COUNT_W'(1) : hit_cnt;
      out_misses   <= (!c_inval && !c_hit) ? miss_next : miss_cnt;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.hit           = out_hit;
  assign rsp.allocated     = out_alloc;
  assign rsp.way_used      = out_way;
  assign rsp.set_used      = out_set;
  assign rsp.evicted_valid = out_ev_valid;
  assign rsp.evicted_tag   = out_ev_tag;
  assign rsp.access_total  = out_access;
  assign rsp.hit_total     = out_hits;
  assign rsp.miss_total    = out_misses;

  // ---------------------------------------------------------------- assertions
  // every counted access is either a hit or a miss
  a_count_balance: assert property (@(posedge clk) disable iff (rst)
    COUNT_W'(hit_cnt + miss_cnt) == access_cnt)
    else $error("hit and miss totals do not add up to the access total");

  // the access counter moves only on a committed load
  a_access_step: assert property (@(posedge clk) disable iff (rst)
    (access_cnt != $past(access_cnt)) |-> ($past(c_go) && !$past(c_inval)))
    else $error("access counter moved without a committed load");

  // a commit never overwrites a response that was not taken
  a_commit_slot: assert property (@(posedge clk) disable iff (rst)
    c_go |-> slot_free)
    else $error("commit while the response register is still held");

  // a committed request always shows up as a response
  a_commit_resp: assert property (@(posedge clk) disable iff (rst)
    c_go |=> out_valid)
    else $error("committed request produced no response");

  // hit and fill are exclusive, and an eviction only comes with a fill
  a_resp_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!(out_hit && out_alloc) && (!out_ev_valid || out_alloc)))
    else $error("inconsistent hit, fill and eviction flags");

endmodule

// File: sv/sactr_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module sactr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
